### hw/rtl/smbd_pkg.sv
// ----------------------------------------------------------------------------
// SplitMix64 bounded draw package
// Shared constants, command codes and sequencer states.
// ----------------------------------------------------------------------------
package smbd_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned CntW  = 7;

  localparam logic [63:0] GoldenStep = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMulA    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB    = 64'h94d049bb133111eb;
  localparam int unsigned FracShift  = 11;

  typedef enum logic [1:0] {
    CmdRaw   = 2'd0,
    CmdFrac  = 2'd1,
    CmdIndex = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    StIdle,
    StMulA,
    StMulB,
    StFinal,
    StFloor,
    StCheck,
    StMod,
    StDone
  } state_e;

  // Control handed from the sequencer to the serial arithmetic unit.
  typedef struct packed {
    logic start_mul;
    logic start_div;
  } arith_ctrl_t;

  typedef struct packed {
    logic busy;
  } arith_stat_t;

endpackage

### hw/rtl/smbd_arith.sv
// ----------------------------------------------------------------------------
// SplitMix64 bounded draw serial arithmetic
// Bit-serial 64x64 low-half multiplier and restoring divider (remainder),
// one bit per cycle on a shared shift register.
// ----------------------------------------------------------------------------
module smbd_arith (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  smbd_pkg::arith_ctrl_t     ctrl_i,
  input  logic [smbd_pkg::DataW-1:0] op_a_i,
  input  logic [smbd_pkg::DataW-1:0] op_b_i,
  output smbd_pkg::arith_stat_t     stat_o,
  output logic [smbd_pkg::DataW-1:0] result_o
);

  localparam int unsigned W = smbd_pkg::DataW;

  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] sh_q, sh_d;
  logic [W-1:0] b_q, b_d;
  logic [smbd_pkg::CntW-1:0] cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         div_q, div_d;
  logic [W:0]   rem_sh;
  logic [W:0]   rem_sub;

  // One bit step of the multiply or divide.
  always_comb begin
    acc_d  = acc_q;
    sh_d   = sh_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    div_d  = div_q;
    rem_sh  = {acc_q, sh_q[W-1]};
    rem_sub = rem_sh - {1'b0, b_q};
    if (ctrl_i.start_mul) begin
      acc_d  = '0;
      sh_d   = op_a_i;
      b_d    = op_b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      div_d  = 1'b0;
    end else if (ctrl_i.start_div) begin
      acc_d  = '0;
      sh_d   = op_a_i;
      b_d    = op_b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      div_d  = 1'b1;
    end else if (busy_q) begin
      if (div_q) begin
        sh_d  = {sh_q[W-2:0], 1'b0};
        acc_d = rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
      end else begin
        // Multiplier bits consumed LSB first; b shifts left each step.
        if (sh_q[0]) begin
          acc_d = acc_q + b_q;
        end
        sh_d = {1'b0, sh_q[W-1:1]};
        b_d  = {b_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == smbd_pkg::CntW'(W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    b_q   <= b_d;
  end

  assign stat_o.busy = busy_q;
  assign result_o    = acc_q;

endmodule

### hw/rtl/splitmix64_bounded_draw_unit.sv
// ----------------------------------------------------------------------------
// SplitMix64 bounded draw unit
// SplitMix64 generator with raw, 0.53 fraction and rejection-sampled index.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake    | Payload
// in      | input     | valid/stall  | command_i, count_i
// out     | output    | valid/stall  | value_o
// cfg     | input     | valid/ready  | cfg_data_i (seed)
//
// A draw is two serial multiplies. Raw and fraction results follow one draw;
// an index request first divides for the floor remainder, draws again after
// each rejection, and ends with a modulo divide.
// Zero count and command 3 show their result in the cycle after acceptance.
// Reset loads a zero seed; a seed write waits while a request is offered.
// A stalled result holds in the output register; once it is taken the unit
// returns to idle and can accept the next request.
// ----------------------------------------------------------------------------
module splitmix64_bounded_draw_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned W = smbd_pkg::DataW;

  smbd_pkg::state_e state_q, state_d;
  smbd_pkg::arith_ctrl_t ctrl;
  smbd_pkg::arith_stat_t stat;
  logic [W-1:0] gen_q, gen_d;
  logic [W-1:0] z_q, z_d;
  logic [W-1:0] floor_q, floor_d;
  logic [W-1:0] count_q;
  logic [1:0]   cmd_q;
  logic [W-1:0] value_q, value_d;
  logic [W-1:0] op_a, op_b;
  logic [W-1:0] arith_res;
  logic         launch;
  logic         first_q, first_d;
  logic [W-1:0] draw_val;
  logic         in_acc;

  // A request offered while idle takes priority over a seed write.
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != smbd_pkg::StIdle);
  assign cfg_ready_o = (state_q == smbd_pkg::StIdle) && !in_valid_i;
  assign out_valid_o = (state_q == smbd_pkg::StDone);
  assign value_o     = value_q;
  assign draw_val    = arith_res ^ {31'd0, arith_res[W-1:31]};

  smbd_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .stat_o  (stat),
    .result_o(arith_res)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      smbd_pkg::StIdle: begin
        if (in_acc) begin
          if (command_i == smbd_pkg::CmdNone ||
              (command_i == smbd_pkg::CmdIndex && count_i == '0)) begin
            state_d = smbd_pkg::StDone;
          end else if (command_i == smbd_pkg::CmdIndex) begin
            state_d = smbd_pkg::StFloor;
          end else begin
            state_d = smbd_pkg::StMulA;
          end
        end
      end
      smbd_pkg::StFloor: if (!stat.busy && !first_q) state_d = smbd_pkg::StMulA;
      smbd_pkg::StMulA:  if (!stat.busy && !first_q) state_d = smbd_pkg::StMulB;
      smbd_pkg::StMulB:  if (!stat.busy && !first_q) state_d = smbd_pkg::StFinal;
      smbd_pkg::StFinal: begin
        if (cmd_q != smbd_pkg::CmdIndex) begin
          state_d = smbd_pkg::StDone;
        end else if (draw_val >= floor_q) begin
          state_d = smbd_pkg::StMod;
        end else begin
          state_d = smbd_pkg::StMulA;
        end
      end
      smbd_pkg::StMod:   if (!stat.busy && !first_q) state_d = smbd_pkg::StDone;
      smbd_pkg::StDone:  if (!out_stall_i) state_d = smbd_pkg::StIdle;
      default:           state_d = smbd_pkg::StIdle;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    launch   = 1'b0;
    ctrl     = '0;
    op_a     = z_q;
    op_b     = smbd_pkg::MixMulA;
    gen_d    = gen_q;
    z_d      = z_q;
    floor_d  = floor_q;
    value_d  = value_q;
    first_d  = 1'b0;
    case (state_q)
      smbd_pkg::StIdle: begin
        value_d = '0;
        if (cfg_valid_i && cfg_ready_o) begin
          gen_d = cfg_data_i;
        end else if (in_acc && command_i != smbd_pkg::CmdNone &&
                     !(command_i == smbd_pkg::CmdIndex && count_i == '0)) begin
          first_d = 1'b1;
          if (command_i != smbd_pkg::CmdIndex) begin
            // Advance the counter and prepare the first mix term.
            gen_d = gen_q + smbd_pkg::GoldenStep;
            z_d   = gen_d ^ {30'd0, gen_d[W-1:30]};
          end
        end
      end
      smbd_pkg::StFloor: begin
        op_a = '0 - count_q;
        op_b = count_q;
        if (first_q) begin
          ctrl.start_div = 1'b1;
        end else if (!stat.busy) begin
          floor_d = arith_res;
          gen_d   = gen_q + smbd_pkg::GoldenStep;
          z_d     = gen_d ^ {30'd0, gen_d[W-1:30]};
          first_d = 1'b1;
        end
      end
      smbd_pkg::StMulA: begin
        op_a = z_q;
        op_b = smbd_pkg::MixMulA;
        if (first_q) begin
          ctrl.start_mul = 1'b1;
        end else if (!stat.busy) begin
          z_d     = arith_res ^ {27'd0, arith_res[W-1:27]};
          first_d = 1'b1;
        end
      end
      smbd_pkg::StMulB: begin
        op_a = z_q;
        op_b = smbd_pkg::MixMulB;
        if (first_q) begin
          ctrl.start_mul = 1'b1;
        end
      end
      smbd_pkg::StFinal: begin
        if (cmd_q == smbd_pkg::CmdRaw) begin
          value_d = draw_val;
        end else if (cmd_q == smbd_pkg::CmdFrac) begin
          value_d = {11'd0, draw_val[W-1:smbd_pkg::FracShift]};
        end else if (draw_val >= floor_q) begin
          z_d     = draw_val;
          first_d = 1'b1;
        end else begin
          // Rejected draw: advance and mix again.
          gen_d   = gen_q + smbd_pkg::GoldenStep;
          z_d     = gen_d ^ {30'd0, gen_d[W-1:30]};
          first_d = 1'b1;
        end
      end
      smbd_pkg::StMod: begin
        op_a = z_q;
        op_b = count_q;
        if (first_q) begin
          ctrl.start_div = 1'b1;
        end else if (!stat.busy) begin
          value_d = arith_res;
        end
      end
      smbd_pkg::StDone: begin
        launch = 1'b0;
      end
      default: begin
        launch = 1'b0;
      end
    endcase
    if (launch) begin
      first_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smbd_pkg::StIdle;
      gen_q   <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      gen_q   <= gen_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q     <= z_d;
    floor_q <= floor_d;
    value_q <= value_d;
    if (in_acc) begin
      cmd_q   <= command_i;
      count_q <= count_i;
    end
  end

endmodule

### hw/rtl/smbd_checker.sv
// ----------------------------------------------------------------------------
// SplitMix64 bounded draw port checker
// Watches the top-level ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module smbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] value_o,
  input logic        cfg_ready_o
);

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o))
    else $error("stalled result changed");

  // A held result blocks new requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request accepted while result pending");

  // An accepted request makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block idle after accepting a request");

  // Configuration only while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !in_stall_o)
    else $error("config ready while busy");

endmodule

bind splitmix64_bounded_draw_unit smbd_checker u_smbd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .value_o    (value_o),
  .cfg_ready_o(cfg_ready_o)
);

### tb/splitmix64_bounded_draw_unit_tb.sv
// ----------------------------------------------------------------------------
// SplitMix64 bounded draw unit testbench
// Drives raw, fraction, index and unused requests under several seeds, with
// random idle cycles on both channels and one long output hold-off. A
// scoreboard predicts every result and compares it with the unit's output.
// ----------------------------------------------------------------------------
module splitmix64_bounded_draw_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned SettleCycles = 600;
  localparam int unsigned LongHold = 2500;

  // Scoreboard: own copy of the generator and a queue of expected values.
  class draw_scoreboard;
    logic [63:0] counter;
    logic [63:0] expected_values[$];
    int unsigned errors;

    function new();
      counter = '0;
      errors = 0;
    endfunction

    function void load_seed(logic [63:0] seed);
      counter = seed;
    endfunction

    // One SplitMix64 step: advance the counter and mix it.
    function logic [63:0] next_draw();
      logic [63:0] z;
      counter = counter + smbd_pkg::GoldenStep;
      z = counter;
      z = (z ^ (z >> 30)) * smbd_pkg::MixMulA;
      z = (z ^ (z >> 27)) * smbd_pkg::MixMulB;
      return z ^ (z >> 31);
    endfunction

    // Unbiased index below n; draws under the rejection floor are discarded.
    function logic [63:0] bounded_index(logic [63:0] n);
      logic [63:0] floor_val;
      logic [63:0] d;
      if (n == '0) return '0;
      floor_val = (64'd0 - n) % n;
      d = next_draw();
      while (d < floor_val) d = next_draw();
      return d % n;
    endfunction

    // Notes an accepted request transaction and queues its expected value.
    function void note_request(smbd_pkg::cmd_e c, logic [63:0] n);
      logic [63:0] v;
      case (c)
        smbd_pkg::CmdRaw:   v = next_draw();
        smbd_pkg::CmdFrac:  v = next_draw() >> smbd_pkg::FracShift;
        smbd_pkg::CmdIndex: v = bounded_index(n);
        default:            v = '0;
      endcase
      expected_values.push_back(v);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Checks one accepted result transaction against the oldest expectation.
    task check_value(logic [63:0] v);
      logic [63:0] e;
      if (expected_values.size() == 0) begin
        report($sformatf("unexpected result value=%h", v));
      end else begin
        e = expected_values.pop_front();
        if (v !== e) report($sformatf("value got %h, want %h", v, e));
      end
    endtask

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  command;
  logic [63:0] count;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_data;

  draw_scoreboard sb;
  bit          no_send_idle;
  bit          no_recv_idle;
  bit          hold_request;
  int unsigned cycles;

  splitmix64_bounded_draw_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .count_i     (count),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .value_o     (value),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offers one request transaction and waits until it is accepted.
  task send_request(smbd_pkg::cmd_e c, logic [63:0] n);
    int unsigned gap;
    gap = no_send_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    count <= n;
    do @(posedge clk); while (in_stall);
    sb.note_request(c, n);
  endtask

  // Writes the seed register; only called while the unit is idle.
  task write_seed(logic [63:0] seed);
    cfg_valid <= 1'b1;
    cfg_data <= seed;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.load_seed(seed);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Random request: mostly valid commands, counts spread over all magnitudes.
  task send_random_request();
    smbd_pkg::cmd_e c;
    logic [63:0] n;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) c = smbd_pkg::CmdRaw;
    else if (pick < 45) c = smbd_pkg::CmdFrac;
    else if (pick < 95) c = smbd_pkg::CmdIndex;
    else c = smbd_pkg::CmdNone;
    pick = $urandom_range(0, 99);
    if (pick < 5) n = '0;
    else if (pick < 35) n = 64'($urandom_range(1, 1000));
    else if (pick < 55) n = 64'($urandom);
    else if (pick < 80) n = {$urandom, $urandom};
    else n = {1'b1, 31'($urandom_range(0, 255)), $urandom};
    send_request(c, n);
  endtask

  // Output side: random stall before each result, one long hold on request.
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold = LongHold;
        hold_request = 1'b0;
      end else begin
        hold = no_recv_idle ? 0 : $urandom_range(0, 14);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      sb.check_value(value);
    end
  end

  // Main sequence: directed requests, then random phases, all but the first under new seeds.
  initial begin
    logic [63:0] seeds[4];
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    command = smbd_pkg::CmdRaw;
    count = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    no_send_idle = 1'b0;
    no_recv_idle = 1'b0;
    hold_request = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset seed of zero.
    send_request(smbd_pkg::CmdRaw, '0);
    send_request(smbd_pkg::CmdFrac, '1);
    send_request(smbd_pkg::CmdIndex, '0);
    send_request(smbd_pkg::CmdIndex, 64'd1);
    send_request(smbd_pkg::CmdIndex, 64'd2);
    send_request(smbd_pkg::CmdIndex, 64'd3);
    send_request(smbd_pkg::CmdIndex, 64'd7);
    send_request(smbd_pkg::CmdIndex, 64'h8000_0000_0000_0000);
    send_request(smbd_pkg::CmdIndex, 64'h8000_0000_0000_0001);
    send_request(smbd_pkg::CmdIndex, 64'hC000_0000_0000_0001);
    send_request(smbd_pkg::CmdIndex, 64'hFFFF_FFFF_FFFF_FFFE);
    send_request(smbd_pkg::CmdIndex, '1);
    send_request(smbd_pkg::CmdIndex, 64'h5555_5555_5555_5555);
    send_request(smbd_pkg::CmdIndex, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(smbd_pkg::CmdNone, '1);
    send_request(smbd_pkg::CmdNone, '0);
    send_request(smbd_pkg::CmdRaw, 64'h1234);
    send_request(smbd_pkg::CmdFrac, '0);
    send_request(smbd_pkg::CmdIndex, 64'h0000_0001_0000_0000);
    wait_drained();

    seeds[0] = '1;
    seeds[1] = '0;
    seeds[2] = {$urandom, $urandom};
    seeds[3] = 64'h8000_0000_0000_0000;
    for (int p = 0; p < 5; p++) begin
      if (p > 0) write_seed(seeds[p - 1]);
      no_recv_idle = (p == 1);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        // Stretches without sender idling; the long hold-off in phase two.
        no_send_idle = ((i / 40) % 3 == 1);
        if (p == 2 && i == 50) begin
          no_send_idle = 1'b1;
          hold_request = 1'b1;
        end
        send_random_request();
      end
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
